### rtl/sgc_pkg.sv
// Package: shared widths, register indexes and state type of the segmented gain calibration core.
package sgc_pkg;

    localparam int MAX_POINTS   = 128;
    localparam int NUM_CHANNELS = 2;
    localparam int TABLE_DEPTH  = NUM_CHANNELS * MAX_POINTS;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CH_W     = $clog2(NUM_CHANNELS);
    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int OFFSET_W = 16;
    localparam int SUM_W    = 18;
    localparam int BOUND_W  = 18;
    localparam int GAIN_W   = 24;
    localparam int VALUE_W  = 41;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = SUM_W + GAIN_W;
    localparam int SEG_W    = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CH1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CH0  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CH1  = 2'd3;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_GAIN,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

### rtl/sgc_in_if.sv
// Interface: input item channel (load or convert) with valid/ready handshake.
interface sgc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic                                channel;
    logic        [sgc_pkg::SAMPLE_W-1:0] sample;
    logic        [sgc_pkg::IDX_W-1:0]    entry_index;
    logic signed [sgc_pkg::BOUND_W-1:0]  entry_bound;
    logic signed [sgc_pkg::GAIN_W-1:0]   entry_gain;

    modport source (
        output valid, op, channel, sample, entry_index, entry_bound, entry_gain,
        input  ready
    );
    modport sink (
        input  valid, op, channel, sample, entry_index, entry_bound, entry_gain,
        output ready
    );
endinterface

### rtl/sgc_out_if.sv
// Interface: calibrated result channel with valid/ready handshake.
interface sgc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sgc_pkg::VALUE_W-1:0] value;
    logic                               segment_hit;
    logic        [sgc_pkg::SEG_W-1:0]   segment_index;

    modport source (output valid, value, segment_hit, segment_index, input ready);
    modport sink   (input  valid, value, segment_hit, segment_index, output ready);
endinterface

### rtl/sgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/segmented_gain_calibration_core.sv
// Top level: two-channel piecewise segment gain calibration with RAM-held tables.
//
//  channel  | dir | transaction                      | payload
//  ---------+-----+----------------------------------+----------------------------------------
//  i_in     | in  | valid & ready                    | op, channel, sample, entry_index/bound/gain
//  o_out    | out | valid & ready                    | value, segment_hit, segment_index
//  cfg      | in  | i_cfg_we                         | i_cfg_idx, i_cfg_data
//
//  Load: written straight into both tables; ready stays high.
//  Convert: one bound RAM read per breakpoint walked; a hit on segment j goes on through
//    the gain read and the multiply, a miss (or fewer than two points) goes straight to
//    the result register; the next item can be taken as soon as the result is registered.
//  One convert is in flight at a time; the result register lets the next item in
//    while a finished result waits to be taken.
//  Reset (synchronous, active low) clears config registers and control; tables are
//    not cleared and must be loaded before use.
module segmented_gain_calibration_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sgc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sgc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sgc_in_if.sink                             i_in,
    sgc_out_if.source                          o_out
);

    // configuration registers
    logic signed [sgc_pkg::OFFSET_W-1:0] r_off0, r_off1;
    logic        [sgc_pkg::CNT_W-1:0]    r_cnt0, r_cnt1;

    // control
    sgc_pkg::t_state r_state, n_state;
    logic            r_rd_vld;
    logic            r_out_vld;

    // convert context
    logic signed [sgc_pkg::SUM_W-1:0]   r_sum;
    logic        [sgc_pkg::CNT_W-1:0]   r_cnt;
    logic        [sgc_pkg::CH_W-1:0]    r_chan;
    logic        [sgc_pkg::CNT_W-1:0]   r_k;      // next bound read
    logic        [sgc_pkg::CNT_W-1:0]   r_rd_k;   // index of bound data now at RAM output
    logic signed [sgc_pkg::BOUND_W-1:0] r_lo;
    logic        [sgc_pkg::IDX_W-1:0]   r_seg;
    logic                               r_hit;
    logic signed [sgc_pkg::VALUE_W-1:0] r_value;

    // result register
    logic signed [sgc_pkg::VALUE_W-1:0] r_out_value;
    logic                               r_out_hit;
    logic        [sgc_pkg::SEG_W-1:0]   r_out_seg;

    // datapath wires
    logic                               in_acc, acc_load, acc_conv;
    logic signed [sgc_pkg::OFFSET_W-1:0] sel_off;
    logic        [sgc_pkg::CNT_W-1:0]   sel_cnt, clamp_cnt;
    logic signed [sgc_pkg::SUM_W-1:0]   in_sum;
    logic signed [sgc_pkg::VALUE_W-1:0] miss_value;
    logic signed [sgc_pkg::VALUE_W-1:0] in_miss_value;
    logic signed [sgc_pkg::PROD_W-1:0]  mul_full;
    logic                               tbl_we;
    logic        [sgc_pkg::ADDR_W-1:0]  tbl_waddr;
    logic                               bound_re, gain_re;
    logic        [sgc_pkg::ADDR_W-1:0]  bound_raddr, gain_raddr;
    logic signed [sgc_pkg::BOUND_W-1:0] bound_rdata;
    logic signed [sgc_pkg::GAIN_W-1:0]  gain_rdata;
    logic                               walk_hit, walk_last;
    logic                               load_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off0 <= '0;
            r_off1 <= '0;
            r_cnt0 <= '0;
            r_cnt1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sgc_pkg::CFG_OFFSET_CH0: r_off0 <= i_cfg_data;
                sgc_pkg::CFG_OFFSET_CH1: r_off1 <= i_cfg_data;
                sgc_pkg::CFG_COUNT_CH0:  r_cnt0 <= i_cfg_data[sgc_pkg::CNT_W-1:0];
                sgc_pkg::CFG_COUNT_CH1:  r_cnt1 <= i_cfg_data[sgc_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    assign in_acc   = i_in.valid && i_in.ready;
    assign acc_load = in_acc && (i_in.op == sgc_pkg::OP_LOAD);
    assign acc_conv = in_acc && (i_in.op == sgc_pkg::OP_CONVERT);

    assign sel_off   = i_in.channel ? r_off1 : r_off0;
    assign sel_cnt   = i_in.channel ? r_cnt1 : r_cnt0;
    // counts above the table size behave as a full table
    assign clamp_cnt = (sel_cnt > sgc_pkg::CNT_W'(sgc_pkg::MAX_POINTS))
                     ? sgc_pkg::CNT_W'(sgc_pkg::MAX_POINTS) : sel_cnt;
    assign in_sum    = $signed({2'b00, i_in.sample})
                     + $signed({{(sgc_pkg::SUM_W-sgc_pkg::OFFSET_W){sel_off[sgc_pkg::OFFSET_W-1]}},
                                sel_off});

    // unscaled value: sum with 16 zero fraction bits
    assign in_miss_value = {{(sgc_pkg::VALUE_W-sgc_pkg::SUM_W-sgc_pkg::FRAC_W)
                             {in_sum[sgc_pkg::SUM_W-1]}}, in_sum, {sgc_pkg::FRAC_W{1'b0}}};
    assign miss_value    = {{(sgc_pkg::VALUE_W-sgc_pkg::SUM_W-sgc_pkg::FRAC_W)
                             {r_sum[sgc_pkg::SUM_W-1]}}, r_sum, {sgc_pkg::FRAC_W{1'b0}}};

    // table write, out-of-range index ignored
    assign tbl_we    = acc_load
                    && ({1'b0, i_in.entry_index} < sgc_pkg::CNT_W'(sgc_pkg::MAX_POINTS));
    assign tbl_waddr = {i_in.channel, i_in.entry_index};

    // ---------------- tables ----------------
    sgc_ram #(
        .WIDTH (sgc_pkg::BOUND_W),
        .DEPTH (sgc_pkg::TABLE_DEPTH)
    ) u_bound_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in.entry_bound),
        .i_re    (bound_re),
        .i_raddr (bound_raddr),
        .o_rdata (bound_rdata)
    );

    sgc_ram #(
        .WIDTH (sgc_pkg::GAIN_W),
        .DEPTH (sgc_pkg::TABLE_DEPTH)
    ) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in.entry_gain),
        .i_re    (gain_re),
        .i_raddr (gain_raddr),
        .o_rdata (gain_rdata)
    );

    assign bound_raddr = {r_chan, r_k[sgc_pkg::IDX_W-1:0]};
    assign gain_raddr  = {r_chan, r_seg};

    // segment j = rd_k - 1 matches when bound[j] <= sum < bound[j+1]
    assign walk_hit  = r_rd_vld && (r_rd_k != '0) && (r_sum >= r_lo) && (r_sum < bound_rdata);
    assign walk_last = r_rd_vld && ((r_rd_k + 1'b1) == r_cnt);

    assign mul_full  = r_sum * gain_rdata;

    assign load_out  = (r_state == sgc_pkg::ST_DONE) && (!r_out_vld || o_out.ready);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgc_pkg::ST_IDLE: begin
                if (acc_conv) begin
                    n_state = (clamp_cnt < sgc_pkg::CNT_W'(2)) ? sgc_pkg::ST_DONE
                                                               : sgc_pkg::ST_WALK;
                end
            end
            sgc_pkg::ST_WALK: begin
                if (walk_hit) begin
                    n_state = sgc_pkg::ST_GAIN;
                end else if (walk_last) begin
                    n_state = sgc_pkg::ST_DONE;
                end
            end
            sgc_pkg::ST_GAIN: n_state = sgc_pkg::ST_MUL;
            sgc_pkg::ST_MUL:  n_state = sgc_pkg::ST_DONE;
            sgc_pkg::ST_DONE: begin
                if (load_out) begin
                    n_state = sgc_pkg::ST_IDLE;
                end
            end
            default: n_state = sgc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        i_in.ready = 1'b0;
        bound_re   = 1'b0;
        gain_re    = 1'b0;
        unique case (r_state)
            sgc_pkg::ST_IDLE: i_in.ready = 1'b1;
            sgc_pkg::ST_WALK: bound_re   = (r_k < r_cnt);
            sgc_pkg::ST_GAIN: gain_re    = 1'b1;
            sgc_pkg::ST_MUL,
            sgc_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sgc_pkg::ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= bound_re;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (acc_conv) begin
            r_sum   <= in_sum;
            r_cnt   <= clamp_cnt;
            r_chan  <= i_in.channel;
            r_k     <= '0;
            r_hit   <= 1'b0;
            r_seg   <= '0;
            r_value <= in_miss_value;
        end
        if (bound_re) begin
            r_k    <= r_k + 1'b1;
            r_rd_k <= r_k;
        end
        if (r_state == sgc_pkg::ST_WALK && r_rd_vld) begin
            r_lo <= bound_rdata;
            if (walk_hit) begin
                r_hit <= 1'b1;
                r_seg <= sgc_pkg::IDX_W'(r_rd_k - 1'b1);
            end else if (walk_last) begin
                r_value <= miss_value;
            end
        end
        if (r_state == sgc_pkg::ST_MUL) begin
            r_value <= mul_full[sgc_pkg::VALUE_W-1:0];
        end
        if (load_out) begin
            r_out_value <= r_value;
            r_out_hit   <= r_hit;
            r_out_seg   <= sgc_pkg::SEG_W'(r_seg);
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.value         = r_out_value;
    assign o_out.segment_hit   = r_out_hit;
    assign o_out.segment_index = r_out_seg;

`ifndef SYNTHESIS
    // tables are written only from an accepted load
    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> (r_state == sgc_pkg::ST_IDLE) && i_in.valid)
        else $error("table write outside idle");

    // a convert blocks further input on the next cycle
    a_conv_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_conv |=> !i_in.ready)
        else $error("input accepted during a convert");

    // the walk, bounded by the active point count, never reads past the table
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bound_re |-> (r_k < sgc_pkg::CNT_W'(sgc_pkg::MAX_POINTS)))
        else $error("bound read beyond table");

    // a finished convert lands in the result register
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_vld && (r_state == sgc_pkg::ST_IDLE))
        else $error("result not registered");

    // a miss always reports segment zero
    a_miss_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_hit) |-> (r_out_seg == '0))
        else $error("segment index on a miss");
`endif

endmodule

### bench/segmented_gain_calibration_core_tb.sv
// Testbench for the segmented gain calibration core: directed and random loads and converts.
module segmented_gain_calibration_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgc_pkg::*;

    // Clock period is 8 ns.
    localparam int SETTLE_CYCLES = 150;  // quiet time after the last result
    localparam int PHASE_ITEMS   = 170;  // random transactions per phase

    // One input transaction, as presented on the input channel.
    typedef struct {
        logic                       op;
        logic                       channel;
        logic [SAMPLE_W-1:0]        sample;
        logic [IDX_W-1:0]           entry_index;
        logic signed [BOUND_W-1:0]  entry_bound;
        logic signed [GAIN_W-1:0]   entry_gain;
    } t_item;

    // One calibrated result, as taken from the output channel.
    typedef struct {
        logic signed [VALUE_W-1:0]  value;
        logic                       segment_hit;
        logic [SEG_W-1:0]           segment_index;
    } t_result;

    // Mirror of the core: config registers, both tables and the queue of
    // calibrated values still owed by the core.
    class seg_cal_mirror;
        logic signed [OFFSET_W-1:0] offset    [NUM_CHANNELS];
        logic [CNT_W-1:0]           count     [NUM_CHANNELS];
        logic signed [BOUND_W-1:0]  bound_tab [NUM_CHANNELS][MAX_POINTS];
        logic signed [GAIN_W-1:0]   gain_tab  [NUM_CHANNELS][MAX_POINTS];
        t_result                    owed_results[$];
        int                         mismatch_count;

        function new();
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                offset[c] = '0;
                count[c]  = '0;
            end
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET_CH0: offset[0] = data[OFFSET_W-1:0];
                CFG_OFFSET_CH1: offset[1] = data[OFFSET_W-1:0];
                CFG_COUNT_CH0:  count[0]  = data[CNT_W-1:0];
                CFG_COUNT_CH1:  count[1]  = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Breakpoints actually in use; counts above the table size saturate.
        function int span(int ch);
            return (int'(count[ch]) > MAX_POINTS) ? MAX_POINTS : int'(count[ch]);
        endfunction

        function t_result calibrate(t_item it);
            t_result r;
            longint  sum;
            longint  prod;
            int      ch;
            int      n;
            ch   = int'(it.channel);
            sum  = longint'(it.sample) + longint'(offset[ch]);
            prod = sum * 65536;
            r.value         = prod[VALUE_W-1:0];
            r.segment_hit   = 1'b0;
            r.segment_index = '0;
            n = span(ch);
            // first segment with bound[j] <= sum < bound[j+1] wins
            for (int j = 0; j + 1 < n && !r.segment_hit; j++) begin
                if (sum >= longint'(bound_tab[ch][j]) && sum < longint'(bound_tab[ch][j+1])) begin
                    prod            = sum * longint'(gain_tab[ch][j]);
                    r.value         = prod[VALUE_W-1:0];
                    r.segment_hit   = 1'b1;
                    r.segment_index = j[SEG_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_item(t_item it);
            if (it.op == OP_CONVERT) begin
                owed_results.push_back(calibrate(it));
            end else begin
                bound_tab[it.channel][it.entry_index] = it.entry_bound;
                gain_tab[it.channel][it.entry_index]  = it.entry_gain;
            end
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("%0t ns MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(t_result got);
            t_result exp;
            if (owed_results.size() == 0) begin
                report_mismatch("result transaction with no convert outstanding");
                return;
            end
            exp = owed_results.pop_front();
            if (got.value !== exp.value)
                report_mismatch($sformatf("value got %0d exp %0d", got.value, exp.value));
            if (got.segment_hit !== exp.segment_hit)
                report_mismatch($sformatf("segment_hit got %b exp %b",
                                          got.segment_hit, exp.segment_hit));
            if (got.segment_index !== exp.segment_index)
                report_mismatch($sformatf("segment_index got %0d exp %0d",
                                          got.segment_index, exp.segment_index));
        endtask

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sgc_in_if  in_ch ();
    sgc_out_if out_ch ();

    segmented_gain_calibration_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    seg_cal_mirror calib;

    // Idle odds in percent, changed per phase by the stimulus process.
    int src_idle_pct;
    int sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Output side: take result transactions and stall ready at random.
    initial begin
        t_result got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.value         = out_ch.value;
                got.segment_hit   = out_ch.segment_hit;
                got.segment_index = out_ch.segment_index;
                calib.check_result(got);
            end
            out_ch.ready <= (int'($urandom_range(99)) >= sink_idle_pct);
        end
    end

    // Random field content; callers then set the fields that matter.
    function automatic t_item random_item();
        t_item it;
        it.op          = 1'($urandom_range(1));
        it.channel     = 1'($urandom_range(1));
        it.sample      = SAMPLE_W'($urandom());
        it.entry_index = IDX_W'($urandom());
        it.entry_bound = BOUND_W'($urandom());
        it.entry_gain  = GAIN_W'($urandom());
        return it;
    endfunction

    // Gains: mostly full-range random, some at the extremes or near unity.
    function automatic logic signed [GAIN_W-1:0] random_gain();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return {1'b0, {(GAIN_W-1){1'b1}}};
        if (r < 8)
            return {1'b1, {(GAIN_W-1){1'b0}}};
        if (r < 30)
            return GAIN_W'(65536 + int'($urandom_range(4096)) - 2048);
        return GAIN_W'($urandom());
    endfunction

    // One input transaction: optional valid gaps, then hold until accepted.
    // Valid is left high on acceptance so back-to-back items need no gap.
    task automatic push_item(input t_item it);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= it.op;
        in_ch.channel     <= it.channel;
        in_ch.sample      <= it.sample;
        in_ch.entry_index <= it.entry_index;
        in_ch.entry_bound <= it.entry_bound;
        in_ch.entry_gain  <= it.entry_gain;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        calib.note_item(it);
    endtask

    task automatic load_entry(input int ch, input int idx, input int bound,
                              input logic signed [GAIN_W-1:0] gain);
        t_item it;
        it             = random_item();
        it.op          = OP_LOAD;
        it.channel     = ch[0];
        it.entry_index = idx[IDX_W-1:0];
        it.entry_bound = bound[BOUND_W-1:0];
        it.entry_gain  = gain;
        push_item(it);
    endtask

    task automatic convert(input int ch, input logic [SAMPLE_W-1:0] s);
        t_item it;
        it         = random_item();
        it.op      = OP_CONVERT;
        it.channel = ch[0];
        it.sample  = s;
        push_item(it);
    endtask

    // Well-formed table: entries 0..len-1 with non-decreasing breakpoints.
    // Zero gaps give empty segments, which the walk must skip.
    task automatic refill_table(input int ch, input int len);
        int b;
        int gap_max;
        b       = int'($urandom_range(140000)) - 45000;
        gap_max = 140000 / len;
        for (int i = 0; i < len; i++) begin
            load_entry(ch, i, b, random_gain());
            b = b + int'($urandom_range(gap_max));
            if (b > 131071)
                b = 131071;
        end
    endtask

    // Samples that land on, just below or just above a breakpoint most of
    // the time, so both edges of each segment get exercised.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int ch);
        int     n;
        int     r;
        int     j;
        longint t;
        n = calib.span(ch);
        r = $urandom_range(99);
        if (n > 0 && r < 60) begin
            j = $urandom_range(n - 1);
            t = longint'(calib.bound_tab[ch][j]) - longint'(calib.offset[ch])
                + longint'(int'($urandom_range(2)) - 1);
            if (t >= 0 && t <= 65535)
                return t[SAMPLE_W-1:0];
        end
        if (r < 65)
            return '0;
        if (r < 70)
            return '1;
        return SAMPLE_W'($urandom());
    endfunction

    // Stop sending and let every owed result drain.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (calib.pending() != 0)
            @(posedge i_clk);
    endtask

    // Loads leave nothing in the queue, so after the drain the core may still
    // be walking; give it a full walk time before touching the registers.
    task automatic go_quiet();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; the core must be idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] off0, input logic [CFG_DATA_W-1:0] off1,
                              input logic [CFG_DATA_W-1:0] cnt0, input logic [CFG_DATA_W-1:0] cnt1);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idxs [4];
        vals = '{off0, off1, cnt0, cnt1};
        idxs = '{CFG_OFFSET_CH0, CFG_OFFSET_CH1, CFG_COUNT_CH0, CFG_COUNT_CH1};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            calib.write_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Main stimulus.
    initial begin
        t_item it;
        int    ch;
        int    pick;
        int    len;
        int    idx;
        int    n_items;
        bit    paused;

        calib = new();
        src_idle_pct  = 7;
        sink_idle_pct = 50;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_LOAD;
        in_ch.channel     <= 1'b0;
        in_ch.sample      <= '0;
        in_ch.entry_index <= '0;
        in_ch.entry_bound <= '0;
        in_ch.entry_gain  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Offsets at both extremes, full tables in use on both channels.
        set_config(16'h8000, 16'h7FFF, 16'd128, 16'd128);

        // Fill every entry of both channels before any convert, so no
        // walk ever reads an entry that was never written.
        refill_table(0, MAX_POINTS);
        refill_table(1, MAX_POINTS);

        // Directed: field extremes in the tables.  The lowest breakpoint at
        // entry 0 and the highest at the last entry keep the tables sorted.
        load_entry(0, 0, -131072, {1'b1, {(GAIN_W-1){1'b0}}});
        load_entry(0, MAX_POINTS - 1, 131071, {1'b0, {(GAIN_W-1){1'b1}}});
        load_entry(1, 0, -131072, {1'b0, {(GAIN_W-1){1'b1}}});
        load_entry(1, MAX_POINTS - 1, 131071, {1'b1, {(GAIN_W-1){1'b0}}});
        // sums at the ends of the range: -32768, 32767, 32767, 98302
        convert(0, 16'h0000);
        convert(0, 16'hFFFF);
        convert(1, 16'h0000);
        convert(1, 16'hFFFF);
        // right on a breakpoint (lower bound is inclusive), one below, one above
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int d = -1; d <= 1; d++) begin
                idx = 1 + c * 60;
                len = int'(calib.bound_tab[c][idx]) - int'(calib.offset[c]) + d;
                if (len >= 0 && len <= 65535)
                    convert(c, len[SAMPLE_W-1:0]);
                else
                    convert(c, pick_sample(c));
            end
        end
        // one more convert per channel with a picked sample
        convert(0, pick_sample(0));
        convert(1, pick_sample(1));

        // Random phases: two with sender 7 / receiver 50 percent idle, two
        // the other way round, two with no idling at all.
        for (int p = 0; p < 6; p++) begin
            go_quiet();
            case (p / 2)
                0: begin src_idle_pct = 7;  sink_idle_pct = 50; end
                1: begin src_idle_pct = 50; sink_idle_pct = 7;  end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            case (p)
                0: set_config(16'h0000, 16'h0000, 16'd8, 16'd128);
                // count 255 saturates to the table size
                1: set_config(16'h8000, 16'h7FFF, 16'd2, 16'h00FF);
                // no segments at all: every sum passes unscaled
                2: set_config(16'h7FFF, 16'h8000, 16'd0, 16'd1);
                3: set_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                              16'd128, 16'd3);
                // upper data bits of a count write are dropped
                4: set_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                              16'hA505, 16'd129);
                default: set_config(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                                    CFG_DATA_W'($urandom_range(200)),
                                    CFG_DATA_W'($urandom_range(200)));
            endcase

            n_items = 0;
            paused  = 1'b0;
            while (n_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                ch   = $urandom_range(1);
                if (pick < 74) begin
                    convert(ch, pick_sample(ch));
                    n_items++;
                end else if (pick < 86) begin
                    // new gain on an entry in use, breakpoint kept in order
                    len = calib.span(ch);
                    idx = (len > 0) ? int'($urandom_range(len - 1))
                                    : int'($urandom_range(MAX_POINTS - 1));
                    load_entry(ch, idx, int'(calib.bound_tab[ch][idx]), random_gain());
                    n_items++;
                end else if (pick < 92) begin
                    len = calib.span(ch);
                    if (len > 32)
                        len = 32;
                    len = $urandom_range((len < 2) ? 2 : len, 2);
                    refill_table(ch, len);
                    n_items += len;
                end else begin
                    // noise: any entry, any breakpoint, any gain
                    it    = random_item();
                    it.op = OP_LOAD;
                    push_item(it);
                    n_items++;
                end
                // hold off the sender once per phase until the core has caught up
                if (!paused && n_items >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_for_results();
                end
            end
        end

        go_quiet();
        if (calib.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### segmented_gain_calibration_core.f
rtl/sgc_pkg.sv
rtl/sgc_in_if.sv
rtl/sgc_out_if.sv
rtl/sgc_ram.sv
rtl/segmented_gain_calibration_core.sv
bench/segmented_gain_calibration_core_tb.sv
